>>> sv/slc_pkg.sv
// Shared types, constants and helpers for the set-associative LRU cache model.
package slc_pkg;

  localparam int MAX_SET_BITS = 8;
  localparam int MAX_WAYS     = 8;
  localparam int NUM_SETS     = 1 << MAX_SET_BITS;
  localparam int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int CNT_W        = $clog2(MAX_WAYS + 1);
  localparam int ADDR_W       = 32;
  localparam int TAG_W        = 32;
  localparam int TOTAL_W      = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 5;
  localparam int SET_BITS_W   = 4;
  localparam int WAYS_W       = 4;
  localparam int BLOCK_BITS_W = 5;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2,
    OP_FETCH  = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_WAYS       = 2'd1,
    CFG_BLOCK_BITS = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOOK
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [WAY_W-1:0] age;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  typedef struct packed {
    logic hit;
    logic evict;
  } lookup_res_t;

  typedef struct packed {
    logic       en;
    logic [1:0] hits;
    logic       miss;
    logic       evict;
  } stat_upd_t;

  // A set that has never been written: every line invalid, ranks in way order.
  function automatic row_t reset_row();
    row_t r;
    for (int i = 0; i < MAX_WAYS; i++) begin
      r[i].valid = 1'b0;
      r[i].tag   = '0;
      r[i].age   = WAY_W'(i);
    end
    return r;
  endfunction

endpackage

>>> sv/slc_row_ram.sv
// One-row-per-set tag memory with registered read data.
module slc_row_ram (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [slc_pkg::SET_W-1:0] rd_addr,
  output slc_pkg::row_t             rd_data,
  input  logic                      wr_en,
  input  logic [slc_pkg::SET_W-1:0] wr_addr,
  input  slc_pkg::row_t             wr_data
);

  slc_pkg::row_t mem [slc_pkg::NUM_SETS];
  slc_pkg::row_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/slc_way_logic.sv
// Tag compare, victim choice and recency update for one set row.
module slc_way_logic (
  input  slc_pkg::row_t               row,
  input  logic [slc_pkg::TAG_W-1:0]   tag,
  input  logic [slc_pkg::CNT_W-1:0]   nways,
  output slc_pkg::row_t               row_nxt,
  output slc_pkg::lookup_res_t        res
);

  logic [slc_pkg::MAX_WAYS-1:0] in_use;
  logic                         hit_any;
  logic                         inv_any;
  logic [slc_pkg::WAY_W-1:0]    hit_idx;
  logic [slc_pkg::WAY_W-1:0]    inv_idx;
  logic [slc_pkg::WAY_W-1:0]    lru_idx;
  logic [slc_pkg::WAY_W-1:0]    oldest;
  logic [slc_pkg::WAY_W-1:0]    sel;
  logic [slc_pkg::WAY_W-1:0]    sel_age;

  always_comb begin
    for (int i = 0; i < slc_pkg::MAX_WAYS; i++) begin
      in_use[i] = (slc_pkg::CNT_W'(i) < nways);
    end
  end

  // Downward scans so that the lowest matching way wins.
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    inv_any = 1'b0;
    inv_idx = '0;
    for (int i = slc_pkg::MAX_WAYS - 1; i >= 0; i--) begin
      if (in_use[i] && row[i].valid && (row[i].tag == tag)) begin
        hit_any = 1'b1;
        hit_idx = slc_pkg::WAY_W'(i);
      end
      if (in_use[i] && !row[i].valid) begin
        inv_any = 1'b1;
        inv_idx = slc_pkg::WAY_W'(i);
      end
    end
  end

  // The least recently used way in use carries the highest rank.
  always_comb begin
    lru_idx = '0;
    oldest  = row[0].age;
    for (int i = 1; i < slc_pkg::MAX_WAYS; i++) begin
      if (in_use[i] && (row[i].age > oldest)) begin
        oldest  = row[i].age;
        lru_idx = slc_pkg::WAY_W'(i);
      end
    end
  end

  always_comb begin
    if (hit_any) begin
      sel = hit_idx;
    end else if (inv_any) begin
      sel = inv_idx;
    end else begin
      sel = lru_idx;
    end
  end

  assign sel_age = row[sel].age;

  always_comb begin
    row_nxt = row;
    if (!hit_any) begin
      row_nxt[sel].valid = 1'b1;
      row_nxt[sel].tag   = tag;
    end
    for (int i = 0; i < slc_pkg::MAX_WAYS; i++) begin
      if (row[i].age < sel_age) begin
        row_nxt[i].age = row[i].age + 1'b1;
      end
    end
    row_nxt[sel].age = '0;
  end

  assign res.hit   = hit_any;
  assign res.evict = !hit_any && !inv_any;

endmodule

>>> sv/slc_stats.sv
// Saturating hit, miss and eviction totals.
module slc_stats (
  input  logic                          clk,
  input  logic                          rst_n,
  input  slc_pkg::stat_upd_t            upd,
  output logic [slc_pkg::TOTAL_W-1:0]   hit_total,
  output logic [slc_pkg::TOTAL_W-1:0]   miss_total,
  output logic [slc_pkg::TOTAL_W-1:0]   eviction_total
);

  logic [slc_pkg::TOTAL_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [slc_pkg::TOTAL_W-1:0] miss_cnt_r, miss_cnt_nxt;
  logic [slc_pkg::TOTAL_W-1:0] evict_cnt_r, evict_cnt_nxt;

  function automatic logic [slc_pkg::TOTAL_W-1:0] sat_add(
    input logic [slc_pkg::TOTAL_W-1:0] v,
    input logic [1:0]                  n
  );
    logic [slc_pkg::TOTAL_W:0] sum;
    sum = {1'b0, v} + (slc_pkg::TOTAL_W + 1)'(n);
    return sum[slc_pkg::TOTAL_W] ? '1 : sum[slc_pkg::TOTAL_W-1:0];
  endfunction

  always_comb begin
    hit_cnt_nxt   = sat_add(hit_cnt_r, upd.hits);
    miss_cnt_nxt  = sat_add(miss_cnt_r, {1'b0, upd.miss});
    evict_cnt_nxt = sat_add(evict_cnt_r, {1'b0, upd.evict});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
    end else if (upd.en) begin
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      evict_cnt_r <= evict_cnt_nxt;
    end
  end

  assign hit_total      = hit_cnt_r;
  assign miss_total     = miss_cnt_r;
  assign eviction_total = evict_cnt_r;

endmodule

>>> sv/set_assoc_lru_cache_model_unit.sv
// Top level of the set-associative LRU cache model (tags only).
//
// An access transaction carries an opcode and a byte address; each one gives
// exactly one result transaction with the hits, misses and evictions it added
// and the running saturating totals. Instruction fetches give a result with
// nothing added.
// Timing: the address is split and the set row read in the cycle after the
// access is taken, and the row is updated in the next; it is written back
// and the result registered once the output register is free. A new access
// is taken in the same cycle that the previous result is registered; the set
// row read and its write-back are not overlapped.
// The output register lets an access be taken while the previous result
// waits; while a result is stalled, the following access waits in the
// write-back cycle and the input channel is stalled.
// Reset clears the totals and one written flag per set, so every line reads
// as invalid straight away with no clearing pass. The configuration port is
// to be written only while no access is outstanding.
module set_assoc_lru_cache_model_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_write_en,
  input  logic [slc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [slc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            in_opcode,
  input  logic [slc_pkg::ADDR_W-1:0]            in_address,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            out_hits_added,
  output logic                                  out_misses_added,
  output logic                                  out_evictions_added,
  output logic [slc_pkg::TOTAL_W-1:0]           out_hit_total,
  output logic [slc_pkg::TOTAL_W-1:0]           out_miss_total,
  output logic [slc_pkg::TOTAL_W-1:0]           out_eviction_total
);

  logic [slc_pkg::SET_BITS_W-1:0]   set_bits_r;
  logic [slc_pkg::WAYS_W-1:0]       ways_r;
  logic [slc_pkg::BLOCK_BITS_W-1:0] block_bits_r;

  slc_pkg::state_t state_r, state_nxt;

  slc_pkg::opcode_t            op_r;
  logic [slc_pkg::ADDR_W-1:0]  addr_r;
  logic [slc_pkg::SET_W-1:0]   set_r;
  logic [slc_pkg::TAG_W-1:0]   tag_r;
  logic                        row_ok_r;
  logic [slc_pkg::NUM_SETS-1:0] row_written_r;

  logic                        out_valid_r;
  logic [1:0]                  out_hits_r;
  logic                        out_miss_r;
  logic                        out_evict_r;

  logic [slc_pkg::SET_BITS_W-1:0] sb;
  logic [slc_pkg::CNT_W-1:0]      nways;
  logic [slc_pkg::ADDR_W-1:0]     addr_shifted;
  logic [slc_pkg::SET_W:0]        set_mask;
  logic [slc_pkg::SET_W-1:0]      set_idx;
  logic [2*slc_pkg::ADDR_W-1:0]   tag_wide;
  logic [slc_pkg::TAG_W-1:0]      tag_idx;

  logic          in_acc;
  logic          done;
  logic          rd_en;
  logic          wr_en;
  slc_pkg::row_t rd_row;
  slc_pkg::row_t cur_row;
  slc_pkg::row_t new_row;
  slc_pkg::lookup_res_t lk;
  slc_pkg::stat_upd_t   upd;
  logic [1:0]    hits_add;
  logic          miss_add;
  logic          evict_add;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= '0;
      ways_r       <= slc_pkg::WAYS_W'(1);
      block_bits_r <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        slc_pkg::CFG_SET_BITS:   set_bits_r   <= cfg_wdata[slc_pkg::SET_BITS_W-1:0];
        slc_pkg::CFG_WAYS:       ways_r       <= cfg_wdata[slc_pkg::WAYS_W-1:0];
        slc_pkg::CFG_BLOCK_BITS: block_bits_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    sb = (set_bits_r > slc_pkg::SET_BITS_W'(slc_pkg::MAX_SET_BITS)) ?
         slc_pkg::SET_BITS_W'(slc_pkg::MAX_SET_BITS) : set_bits_r;
    if (ways_r == '0) begin
      nways = slc_pkg::CNT_W'(1);
    end else if (ways_r > slc_pkg::WAYS_W'(slc_pkg::MAX_WAYS)) begin
      nways = slc_pkg::CNT_W'(slc_pkg::MAX_WAYS);
    end else begin
      nways = slc_pkg::CNT_W'(ways_r);
    end
  end

  // Address split; a tag shifted wholly out of the word comes out as zero.
  always_comb begin
    addr_shifted = addr_r >> block_bits_r;
    set_mask     = ((slc_pkg::SET_W + 1)'(1) << sb) - 1'b1;
    set_idx      = addr_shifted[slc_pkg::SET_W-1:0] & set_mask[slc_pkg::SET_W-1:0];
    tag_wide     = {{slc_pkg::ADDR_W{1'b0}}, addr_r} >> (6'(block_bits_r) + 6'(sb));
    tag_idx      = tag_wide[slc_pkg::TAG_W-1:0];
  end

  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      slc_pkg::ST_IDLE: if (in_acc) state_nxt = slc_pkg::ST_READ;
      slc_pkg::ST_READ: state_nxt = slc_pkg::ST_LOOK;
      slc_pkg::ST_LOOK: begin
        if (done) begin
          state_nxt = in_acc ? slc_pkg::ST_READ : slc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = slc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    done  = 1'b0;
    rd_en = 1'b0;
    unique case (state_r)
      slc_pkg::ST_IDLE: ;
      slc_pkg::ST_READ: rd_en = 1'b1;
      slc_pkg::ST_LOOK: done = !out_valid_r || !out_stall;
      default: ;
    endcase
    in_stall = !((state_r == slc_pkg::ST_IDLE) || done);
  end

  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= slc_pkg::opcode_t'(in_opcode);
      addr_r <= in_address;
    end
    if (rd_en) begin
      set_r    <= set_idx;
      tag_r    <= tag_idx;
      row_ok_r <= row_written_r[set_idx];
    end
  end

  assign wr_en = done && (op_r != slc_pkg::OP_FETCH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_written_r <= '0;
    end else if (wr_en) begin
      row_written_r[set_r] <= 1'b1;
    end
  end

  slc_row_ram u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (set_idx),
    .rd_data (rd_row),
    .wr_en   (wr_en),
    .wr_addr (set_r),
    .wr_data (new_row)
  );

  assign cur_row = row_ok_r ? rd_row : slc_pkg::reset_row();

  slc_way_logic u_way (
    .row     (cur_row),
    .tag     (tag_r),
    .nways   (nways),
    .row_nxt (new_row),
    .res     (lk)
  );

  // The second lookup of a modify hits the line just made most recent and
  // leaves the row unchanged, so it only adds a hit.
  always_comb begin
    hits_add  = '0;
    miss_add  = 1'b0;
    evict_add = 1'b0;
    case (op_r) inside
      slc_pkg::OP_LOAD, slc_pkg::OP_STORE: begin
        hits_add  = {1'b0, lk.hit};
        miss_add  = !lk.hit;
        evict_add = lk.evict;
      end
      slc_pkg::OP_MODIFY: begin
        hits_add  = lk.hit ? 2'd2 : 2'd1;
        miss_add  = !lk.hit;
        evict_add = lk.evict;
      end
      default: ;
    endcase
  end

  assign upd.en    = done;
  assign upd.hits  = hits_add;
  assign upd.miss  = miss_add;
  assign upd.evict = evict_add;

  slc_stats u_stats (
    .clk            (clk),
    .rst_n          (rst_n),
    .upd            (upd),
    .hit_total      (out_hit_total),
    .miss_total     (out_miss_total),
    .eviction_total (out_eviction_total)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_hits_r  <= hits_add;
      out_miss_r  <= miss_add;
      out_evict_r <= evict_add;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hits_added      = out_hits_r;
  assign out_misses_added    = out_miss_r;
  assign out_evictions_added = out_evict_r;

endmodule

>>> sv/slc_checker.sv
// Port-level checks for the cache model top level, bound to every instance.
module slc_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic [1:0]                            out_hits_added,
  input logic                                  out_misses_added,
  input logic                                  out_evictions_added,
  input logic [slc_pkg::TOTAL_W-1:0]           out_hit_total,
  input logic [slc_pkg::TOTAL_W-1:0]           out_miss_total,
  input logic [slc_pkg::TOTAL_W-1:0]           out_eviction_total
);

  // A stalled result must stay in place; the added counts and the hit total are checked.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hits_added) &&
      $stable(out_misses_added) && $stable(out_evictions_added) &&
      $stable(out_hit_total))
    else $error("stalled result changed");

  // An eviction only ever comes with a miss.
  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evictions_added |-> out_misses_added)
    else $error("eviction without a miss");

  // At most two hits, and a missing access adds at most one.
  a_hits_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hits_added != 2'd3) &&
      !(out_misses_added && (out_hits_added == 2'd2)))
    else $error("impossible hit count");

  // Totals never go down while out of reset.
  a_totals_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_hit_total >= $past(out_hit_total)) &&
      (out_miss_total >= $past(out_miss_total)) &&
      (out_eviction_total >= $past(out_eviction_total)))
    else $error("running total decreased");

endmodule

bind set_assoc_lru_cache_model_unit slc_checker u_slc_checker (.*);

>>> tb/set_assoc_lru_cache_model_unit_tb.sv
// Self-checking testbench for the set-associative LRU cache model, with a tag-store predictor.
module set_assoc_lru_cache_model_unit_tb;

  localparam int LINES        = slc_pkg::NUM_SETS * slc_pkg::MAX_WAYS;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 235;

  typedef struct packed {
    logic [1:0]                  hits;
    logic                        miss;
    logic                        evict;
    logic [slc_pkg::TOTAL_W-1:0] hit_total;
    logic [slc_pkg::TOTAL_W-1:0] miss_total;
    logic [slc_pkg::TOTAL_W-1:0] evict_total;
  } access_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_write_en;
  logic [slc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [slc_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           in_valid;
  logic                           in_stall;
  logic [1:0]                     in_opcode;
  logic [slc_pkg::ADDR_W-1:0]     in_address;
  logic                           out_valid;
  logic                           out_stall;
  logic [1:0]                     out_hits_added;
  logic                           out_misses_added;
  logic                           out_evictions_added;
  logic [slc_pkg::TOTAL_W-1:0]    out_hit_total;
  logic [slc_pkg::TOTAL_W-1:0]    out_miss_total;
  logic [slc_pkg::TOTAL_W-1:0]    out_eviction_total;

  // Predictor state: one copy of the tag store, the totals and the registers.
  bit                               line_live [LINES];
  logic [slc_pkg::TAG_W-1:0]        line_key  [LINES];
  int unsigned                      line_rank [LINES];
  logic [slc_pkg::SET_BITS_W-1:0]   cur_set_bits;
  logic [slc_pkg::WAYS_W-1:0]       cur_ways;
  logic [slc_pkg::BLOCK_BITS_W-1:0] cur_block_bits;
  logic [slc_pkg::TOTAL_W-1:0]      hits_seen;
  logic [slc_pkg::TOTAL_W-1:0]      misses_seen;
  logic [slc_pkg::TOTAL_W-1:0]      evictions_seen;
  access_result_t                   pending_results [$];

  int          errors        = 0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          hold_requests = 0;
  int          hold_served   = 0;
  int unsigned cycles        = 0;

  set_assoc_lru_cache_model_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_write_en        (cfg_write_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_address          (in_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_hits_added      (out_hits_added),
    .out_misses_added    (out_misses_added),
    .out_evictions_added (out_evictions_added),
    .out_hit_total       (out_hit_total),
    .out_miss_total      (out_miss_total),
    .out_eviction_total  (out_eviction_total)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [slc_pkg::TOTAL_W-1:0] sat_inc(logic [slc_pkg::TOTAL_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic int eff_set_bits();
    return (cur_set_bits > slc_pkg::MAX_SET_BITS) ? slc_pkg::MAX_SET_BITS
                                                  : int'(cur_set_bits);
  endfunction

  function automatic int eff_ways();
    if (cur_ways == 0) return 1;
    return (cur_ways > slc_pkg::MAX_WAYS) ? slc_pkg::MAX_WAYS : int'(cur_ways);
  endfunction

  function automatic void clear_cache_state();
    for (int i = 0; i < LINES; i++) begin
      line_live[i] = 1'b0;
      line_key[i]  = '0;
      line_rank[i] = i % slc_pkg::MAX_WAYS;
    end
    cur_set_bits   = '0;
    cur_ways       = slc_pkg::WAYS_W'(1);
    cur_block_bits = '0;
    hits_seen      = '0;
    misses_seen    = '0;
    evictions_seen = '0;
  endfunction

  // Ranks run over every way of the set, in use or not, so they stay a permutation.
  function automatic void make_recent(int base, int w);
    int unsigned old;
    old = line_rank[base + w];
    for (int i = 0; i < slc_pkg::MAX_WAYS; i++)
      if (line_rank[base + i] < old) line_rank[base + i]++;
    line_rank[base + w] = 0;
  endfunction

  function automatic void lookup_line(int base, int nw, logic [slc_pkg::TAG_W-1:0] key,
                                      output bit hit, output bit evict);
    int          victim;
    int unsigned oldest;
    hit   = 1'b0;
    evict = 1'b0;
    for (int i = 0; i < nw; i++) begin
      if (line_live[base + i] && line_key[base + i] == key) begin
        hit = 1'b1;
        make_recent(base, i);
        return;
      end
    end
    victim = nw;
    for (int i = 0; i < nw; i++) begin
      if (!line_live[base + i]) begin
        victim = i;
        break;
      end
    end
    if (victim == nw) begin
      oldest = 0;
      victim = 0;
      for (int i = 0; i < nw; i++) begin
        if (line_rank[base + i] > oldest || i == 0) begin
          oldest = line_rank[base + i];
          victim = i;
        end
      end
      evict = 1'b1;
    end
    line_live[base + victim] = 1'b1;
    line_key[base + victim]  = key;
    make_recent(base, victim);
  endfunction

  function automatic access_result_t predict_access(slc_pkg::opcode_t op,
                                                    logic [slc_pkg::ADDR_W-1:0] addr);
    access_result_t            r;
    logic [63:0]               wide;
    int                        sb;
    int                        bb;
    int                        base;
    int                        n;
    logic [slc_pkg::TAG_W-1:0] key;
    bit                        hit;
    bit                        evict;
    r = '0;
    if (op != slc_pkg::OP_FETCH) begin
      sb   = eff_set_bits();
      bb   = int'(cur_block_bits);
      wide = {32'd0, addr};
      // Shifts are done at 64 bits so that a wide offset leaves a tag of zero.
      base = int'((wide >> bb) & ((64'd1 << sb) - 64'd1)) * slc_pkg::MAX_WAYS;
      key  = slc_pkg::TAG_W'(wide >> (bb + sb));
      n    = (op == slc_pkg::OP_MODIFY) ? 2 : 1;
      for (int k = 0; k < n; k++) begin
        lookup_line(base, eff_ways(), key, hit, evict);
        if (hit) begin
          r.hits    = r.hits + 2'd1;
          hits_seen = sat_inc(hits_seen);
        end else begin
          r.miss      = 1'b1;
          misses_seen = sat_inc(misses_seen);
          if (evict) begin
            r.evict        = 1'b1;
            evictions_seen = sat_inc(evictions_seen);
          end
        end
      end
    end
    r.hit_total   = hits_seen;
    r.miss_total  = misses_seen;
    r.evict_total = evictions_seen;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    if (errors <= 50)
      $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, got);
  endtask

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) report_mismatch(what, want, got);
  endtask

  // Result checker: every transaction on the result channel is matched in order.
  always @(posedge clk) begin
    access_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no access outstanding", 32'd0, 32'd1);
      end else begin
        want = pending_results.pop_front();
        check_field("hits_added", 32'(want.hits), 32'(out_hits_added));
        check_field("misses_added", 32'(want.miss), 32'(out_misses_added));
        check_field("evictions_added", 32'(want.evict), 32'(out_evictions_added));
        check_field("hit_total", want.hit_total, out_hit_total);
        check_field("miss_total", want.miss_total, out_miss_total);
        check_field("eviction_total", want.evict_total, out_eviction_total);
      end
    end
  end

  // Result receiver: random stalls, or one long hold-off when asked for.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_access(slc_pkg::opcode_t op, logic [slc_pkg::ADDR_W-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_address <= addr;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_access(op, addr));
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(slc_pkg::cfg_reg_t idx, logic [slc_pkg::CFG_DATA_W-1:0] value);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_wdata    <= value;
    @(posedge clk);
    case (idx)
      slc_pkg::CFG_SET_BITS:   cur_set_bits   = value[slc_pkg::SET_BITS_W-1:0];
      slc_pkg::CFG_WAYS:       cur_ways       = value[slc_pkg::WAYS_W-1:0];
      slc_pkg::CFG_BLOCK_BITS: cur_block_bits = value[slc_pkg::BLOCK_BITS_W-1:0];
      default: ;
    endcase
  endtask

  // Registers are only touched once every outstanding access has returned.
  task automatic apply_config(int sb, int nw, int bb);
    stop_sending();
    wait_drain();
    write_register(slc_pkg::CFG_SET_BITS, slc_pkg::CFG_DATA_W'(sb));
    write_register(slc_pkg::CFG_WAYS, slc_pkg::CFG_DATA_W'(nw));
    write_register(slc_pkg::CFG_BLOCK_BITS, slc_pkg::CFG_DATA_W'(bb));
    cfg_write_en <= 1'b0;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin
        send_idle_pct = 10;
        stall_pct     = 74;
      end
      1: begin
        send_idle_pct = 74;
        stall_pct     = 10;
      end
      default: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
    endcase
  endtask

  function automatic slc_pkg::opcode_t random_op();
    int r;
    r = $urandom_range(99);
    if (r < 35) return slc_pkg::OP_LOAD;
    if (r < 60) return slc_pkg::OP_STORE;
    if (r < 90) return slc_pkg::OP_MODIFY;
    return slc_pkg::OP_FETCH;
  endfunction

  // Tags come from a small pool and sets mostly from the first few, so that
  // hits, fills and evictions all turn up; one address in ten is pure noise.
  function automatic logic [slc_pkg::ADDR_W-1:0] make_address(
    int n_tags, logic [slc_pkg::TAG_W-1:0] tag_base);
    logic [63:0]               a;
    int                        sb;
    int                        bb;
    logic [slc_pkg::TAG_W-1:0] key;
    logic [31:0]               set_idx;
    if ($urandom_range(9) == 0) return $urandom;
    sb      = eff_set_bits();
    bb      = int'(cur_block_bits);
    key     = tag_base + $urandom_range(n_tags - 1);
    set_idx = ($urandom_range(3) != 0) ? $urandom_range(3) : $urandom;
    a = (64'(key) << (bb + sb))
      | ((64'(set_idx) & ((64'd1 << sb) - 64'd1)) << bb)
      | (64'($urandom) & ((64'd1 << bb) - 64'd1));
    return a[slc_pkg::ADDR_W-1:0];
  endfunction

  task automatic test_directed_cases();
    set_idling(2);
    // Reset configuration: one set, one way, no offset.
    send_access(slc_pkg::OP_FETCH, 32'h0000_0000);
    send_access(slc_pkg::OP_LOAD, 32'h0000_0000);
    send_access(slc_pkg::OP_LOAD, 32'h0000_0000);
    send_access(slc_pkg::OP_STORE, 32'h0000_0001);
    send_access(slc_pkg::OP_MODIFY, 32'hFFFF_FFFF);
    send_access(slc_pkg::OP_MODIFY, 32'hFFFF_FFFF);
    send_access(slc_pkg::OP_FETCH, 32'hFFFF_FFFF);
    // Oversized set and way counts are clamped, and the offset eats the whole tag.
    apply_config(15, 15, 24);
    send_access(slc_pkg::OP_LOAD, 32'hAB00_0000);
    send_access(slc_pkg::OP_LOAD, 32'hAB12_3456);
    send_access(slc_pkg::OP_STORE, 32'h0100_0000);
    send_access(slc_pkg::OP_MODIFY, 32'h02FF_FFFF);
    send_access(slc_pkg::OP_FETCH, 32'hAB00_0000);
    // A way count of zero behaves as a single way.
    apply_config(1, 0, 4);
    send_access(slc_pkg::OP_LOAD, 32'h0000_0020);
    send_access(slc_pkg::OP_LOAD, 32'h0000_0040);
    send_access(slc_pkg::OP_LOAD, 32'h0000_0040);
    // Two ways: the refreshed line survives and the older one is evicted.
    apply_config(1, 2, 4);
    send_access(slc_pkg::OP_LOAD, 32'h0000_0020);
    send_access(slc_pkg::OP_LOAD, 32'h0000_0040);
    send_access(slc_pkg::OP_LOAD, 32'h0000_002F);
    send_access(slc_pkg::OP_STORE, 32'h0000_0060);
    send_access(slc_pkg::OP_LOAD, 32'h0000_0040);
    send_access(slc_pkg::OP_MODIFY, 32'h0000_0060);
    send_access(slc_pkg::OP_LOAD, 32'h0000_0030);
  endtask

  task automatic test_random_traffic();
    int                        phase_cfg [8][3];
    logic [slc_pkg::TAG_W-1:0] tag_base;
    int                        n_tags;
    phase_cfg = '{'{3, 4, 4}, '{8, 8, 2}, '{0, 8, 0}, '{2, 2, 24},
                  '{12, 0, 6}, '{5, 3, 1}, '{8, 8, 24}, '{15, 2, 24}};
    for (int p = 0; p < 8; p++) begin
      apply_config(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2]);
      set_idling(p * 3 / 8);
      tag_base = $urandom;
      n_tags   = eff_ways() + 2;
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_access(random_op(), make_address(n_tags, tag_base));
    end
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure_fill();
    logic [slc_pkg::TAG_W-1:0] tag_base;
    apply_config(4, 4, 3);
    set_idling(2);
    tag_base = $urandom;
    hold_requests++;
    for (int i = 0; i < 40; i++)
      send_access(random_op(), make_address(6, tag_base));
  endtask

  // The sender stops until every result is back, then resumes.
  task automatic test_sender_pause();
    logic [slc_pkg::TAG_W-1:0] tag_base;
    set_idling(0);
    tag_base = $urandom;
    for (int i = 0; i < 10; i++)
      send_access(random_op(), make_address(6, tag_base));
    stop_sending();
    wait_drain();
    for (int i = 0; i < 10; i++)
      send_access(random_op(), make_address(6, tag_base));
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_write_en = 1'b0;
    cfg_index    = slc_pkg::CFG_SET_BITS;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_opcode    = slc_pkg::OP_LOAD;
    in_address   = '0;
    clear_cache_state();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_traffic();
    test_backpressure_fill();
    test_sender_pause();

    stop_sending();
    wait_drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> set_assoc_lru_cache_model_unit.f
sv/slc_pkg.sv
sv/slc_row_ram.sv
sv/slc_way_logic.sv
sv/slc_stats.sv
sv/set_assoc_lru_cache_model_unit.sv
sv/slc_checker.sv
tb/set_assoc_lru_cache_model_unit_tb.sv
